// ===== src/esd_pkg.sv =====
// shared types, character codes and helpers for the escape sequence decoder
package esd_pkg;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_PLAIN = 3'd1;
  localparam logic [2:0] PH_ESC   = 3'd2;
  localparam logic [2:0] PH_HEX1  = 3'd3;
  localparam logic [2:0] PH_HEX2  = 3'd4;
  localparam logic [2:0] PH_OCT   = 3'd5;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_E         = 8'h65;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_LA        = 8'h61;
  localparam logic [7:0] CH_LF        = 8'h66;
  localparam logic [7:0] CH_UA        = 8'h41;
  localparam logic [7:0] CH_UF        = 8'h46;

  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_TAB = 8'h09;
  localparam logic [7:0] CODE_ESC = 8'h1B;

  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] accum;
    logic [1:0] digit_count;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
  } res_t;

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      v = b - CH_ZERO;
    end else if (b >= CH_LA && b <= CH_LF) begin
      v = b - CH_LA + 8'd10;
    end else if (b >= CH_UA && b <= CH_UF) begin
      v = b - CH_UA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

// ===== src/esd_decode.sv =====
// one-byte decode step: next state and up to two results
module esd_decode (
  input  esd_pkg::state_t state_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output esd_pkg::state_t state_o,
  output esd_pkg::res_t   res0_o,
  output esd_pkg::res_t   res1_o,
  output logic [1:0]      res_cnt_o
);

  always_comb begin
    logic [2:0] ph;
    logic [7:0] ac;
    logic [1:0] dc;
    logic [1:0] dc_inc;
    logic [7:0] oct_acc;
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       is_oct;

    ph      = state_i.phase;
    ac      = state_i.accum;
    dc      = state_i.digit_count;
    n       = 2'd0;
    b0      = 8'd0;
    b1      = 8'd0;
    is_oct  = (byte_i >= esd_pkg::CH_ZERO) && (byte_i <= esd_pkg::CH_SEVEN);
    oct_acc = {state_i.accum[4:0], byte_i[2:0]};
    dc_inc  = state_i.digit_count + 2'd1;

    unique case (state_i.phase)
      esd_pkg::PH_START: begin
        ph = esd_pkg::PH_PLAIN;
      end
      esd_pkg::PH_ESC: begin
        ph = esd_pkg::PH_PLAIN;
        unique case (byte_i)
          esd_pkg::CH_N: begin
            n  = 2'd1;
            b0 = esd_pkg::CODE_LF;
          end
          esd_pkg::CH_T: begin
            n  = 2'd1;
            b0 = esd_pkg::CODE_TAB;
          end
          esd_pkg::CH_E: begin
            n  = 2'd1;
            b0 = esd_pkg::CODE_ESC;
          end
          esd_pkg::CH_BACKSLASH, esd_pkg::CH_SQUOTE, esd_pkg::CH_DQUOTE: begin
            n  = 2'd1;
            b0 = byte_i;
          end
          esd_pkg::CH_X: begin
            ac = 8'd0;
            ph = esd_pkg::PH_HEX1;
          end
          esd_pkg::CH_ZERO: begin
            ac = 8'd0;
            dc = 2'd0;
            if (last_i) begin
              n  = 2'd1;
              b0 = 8'd0;
            end else begin
              ph = esd_pkg::PH_OCT;
            end
          end
          default: begin
          end
        endcase
      end
      esd_pkg::PH_HEX1: begin
        ac = {esd_pkg::hex_value(byte_i), 4'd0};
        ph = esd_pkg::PH_HEX2;
      end
      esd_pkg::PH_HEX2: begin
        n  = 2'd1;
        b0 = {state_i.accum[7:4], esd_pkg::hex_value(byte_i)};
        ph = esd_pkg::PH_PLAIN;
      end
      esd_pkg::PH_OCT: begin
        if (is_oct) begin
          ac = oct_acc;
          dc = dc_inc;
          if (dc_inc == esd_pkg::OCT_MAX_DIGITS || last_i) begin
            n  = 2'd1;
            b0 = oct_acc;
            ph = esd_pkg::PH_PLAIN;
            dc = 2'd0;
          end
        end else begin
          // run broken: emit its value, then treat the byte as plain
          n  = 2'd1;
          b0 = state_i.accum;
          ph = esd_pkg::PH_PLAIN;
          dc = 2'd0;
          if (byte_i == esd_pkg::CH_BACKSLASH) begin
            if (last_i) begin
              n  = 2'd2;
              b1 = esd_pkg::CH_BACKSLASH;
            end else begin
              ph = esd_pkg::PH_ESC;
            end
          end else begin
            n  = 2'd2;
            b1 = byte_i;
          end
        end
      end
      default: begin
        ph = esd_pkg::PH_PLAIN;
        if (byte_i == esd_pkg::CH_BACKSLASH) begin
          if (last_i) begin
            n  = 2'd1;
            b0 = esd_pkg::CH_BACKSLASH;
          end else begin
            ph = esd_pkg::PH_ESC;
          end
        end else begin
          n  = 2'd1;
          b0 = byte_i;
        end
      end
    endcase

    res0_o.out_byte   = b0;
    res0_o.byte_valid = 1'b1;
    res0_o.run_last   = (n == 2'd1);
    res0_o.string_end = (n == 2'd1) && last_i;
    res1_o.out_byte   = b1;
    res1_o.byte_valid = 1'b1;
    res1_o.run_last   = 1'b1;
    res1_o.string_end = last_i;
    res_cnt_o         = n;

    if (last_i) begin
      // end of string: back to reset, and mark the end if nothing was emitted
      ph = esd_pkg::PH_START;
      ac = 8'd0;
      dc = 2'd0;
      if (n == 2'd0) begin
        res_cnt_o         = 2'd1;
        res0_o.out_byte   = 8'd0;
        res0_o.byte_valid = 1'b0;
        res0_o.run_last   = 1'b1;
        res0_o.string_end = 1'b1;
      end
    end

    state_o.phase       = ph;
    state_o.accum       = ac;
    state_o.digit_count = dc;
  end

endmodule

// ===== src/escape_sequence_decoder.sv =====
// top level of the escape sequence decoder: input register, decode step, output buffer
// Decodes a C-style escaped string, dropping the first byte of each string. Bytes
// enter a one-deep input register; the decode step then updates the phase, accumulator
// and digit count and loads a two-entry result buffer. The block takes one byte per
// cycle while the output accepts results; it stalls when the receiver holds off, and a
// byte that ends an octal run and is itself emitted yields two results and holds the
// input while the buffer drains. A byte is registered in the input register and its
// results in the result buffer. Every byte with tlast set produces at least one
// result; a string end that emits no byte gives a single result with tuser low.
module escape_sequence_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // in_byte[7:0]
  input  logic        s_axis_tlast_i,   // in_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // out_byte[7:0], run_last[8], zero[15:9]
  output logic        m_axis_tlast_o,   // string_end
  output logic        m_axis_tuser_o    // byte_valid
);

  logic            in_vld_q;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  esd_pkg::state_t st_q;
  esd_pkg::state_t st_d;
  esd_pkg::res_t   res0;
  esd_pkg::res_t   res1;
  logic [1:0]      res_cnt;
  esd_pkg::res_t   slot0_q;
  esd_pkg::res_t   slot1_q;
  logic [1:0]      cnt_q;
  logic            pop;
  logic            fire;
  logic            in_acc;

  assign pop             = (cnt_q != 2'd0) && m_axis_tready_i;
  assign fire            = in_vld_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready_i));
  assign s_axis_tready_o = !in_vld_q || fire;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  esd_decode u_decode (
    .state_i   (st_q),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .state_o   (st_d),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase       <= esd_pkg::PH_START;
      st_q.accum       <= 8'd0;
      st_q.digit_count <= 2'd0;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (fire && res_cnt != 2'd0) begin
      cnt_q <= res_cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_cnt != 2'd0) begin
      slot0_q <= res0;
      slot1_q <= res1;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {7'd0, slot0_q.run_last, slot0_q.out_byte};
  assign m_axis_tlast_o  = slot0_q.string_end;
  assign m_axis_tuser_o  = slot0_q.byte_valid;

endmodule

// ===== tb/sv/esd_checker.sv =====
// checker for the escape sequence decoder: predicts decoded bytes and compares the result stream
module esd_checker
  import esd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  input  logic        m_tlast_i,
  input  logic        m_tuser_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          bytes_o,
  output int          results_o,
  output int          doubles_o
);

  logic [2:0] phase_q;
  logic [7:0] accum_q;
  logic [1:0] count_q;
  logic [7:0] step_out[$];
  res_t       decoded_q[$];

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 4'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LF) return 4'(c - CH_LA + 8'd10);
    if (c >= CH_UA && c <= CH_UF) return 4'(c - CH_UA + 8'd10);
    return 4'h0;
  endfunction

  task automatic queue_byte(input logic [7:0] c);
    step_out = {step_out, c};
  endtask

  task automatic take_literal(input logic [7:0] c, input logic fin);
    if (c == CH_BACKSLASH && !fin) begin
      phase_q = PH_ESC;
    end else begin
      queue_byte(c);
      phase_q = PH_PLAIN;
    end
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic fin);
    res_t r;
    int   n;
    step_out.delete();
    case (phase_q)
      PH_START: begin
        phase_q = PH_PLAIN;
      end
      PH_ESC: begin
        phase_q = PH_PLAIN;
        case (c)
          CH_N: queue_byte(CODE_LF);
          CH_T: queue_byte(CODE_TAB);
          CH_E: queue_byte(CODE_ESC);
          CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE: queue_byte(c);
          CH_X: begin
            accum_q = 8'h00;
            phase_q = PH_HEX1;
          end
          CH_ZERO: begin
            accum_q = 8'h00;
            count_q = 2'd0;
            if (fin) queue_byte(8'h00);
            else phase_q = PH_OCT;
          end
          default: ;
        endcase
      end
      PH_HEX1: begin
        accum_q = {hex_nibble(c), 4'h0};
        phase_q = PH_HEX2;
      end
      PH_HEX2: begin
        queue_byte(accum_q | {4'h0, hex_nibble(c)});
        phase_q = PH_PLAIN;
      end
      PH_OCT: begin
        if (c >= CH_ZERO && c <= CH_SEVEN) begin
          accum_q = {accum_q[4:0], c[2:0]};
          count_q = count_q + 2'd1;
          if (count_q >= OCT_MAX_DIGITS || fin) begin
            queue_byte(accum_q);
            phase_q = PH_PLAIN;
            count_q = 2'd0;
          end
        end else begin
          // a non-octal byte closes the run, then counts as an ordinary byte
          queue_byte(accum_q);
          count_q = 2'd0;
          take_literal(c, fin);
        end
      end
      default: take_literal(c, fin);
    endcase

    n = step_out.size();
    if (n == 2) doubles_o++;
    if (n == 0 && fin) begin
      r.out_byte   = 8'h00;
      r.byte_valid = 1'b0;
      r.run_last   = 1'b1;
      r.string_end = 1'b1;
      decoded_q = {decoded_q, r};
    end
    for (int k = 0; k < n; k++) begin
      r.out_byte   = step_out[k];
      r.byte_valid = 1'b1;
      r.run_last   = (k == n - 1);
      r.string_end = (k == n - 1) && fin;
      decoded_q = {decoded_q, r};
    end
    if (fin) begin
      phase_q = PH_START;
      accum_q = 8'h00;
      count_q = 2'd0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t: %s mismatch on result %0d: got %0h, expected %0h",
             $time, what, results_o, got, want);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      phase_q = PH_START;
      accum_q = 8'h00;
      count_q = 2'd0;
      decoded_q.delete();
      fail_cnt_o = 0;
      bytes_o    = 0;
      results_o  = 0;
      doubles_o  = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        decode_byte(s_tdata_i, s_tlast_i);
        bytes_o++;
      end
      if (m_tvalid_i && m_tready_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("nothing pending, out_byte", m_tdata_i[7:0], 8'h00);
        end else begin
          want = decoded_q.pop_front();
          if (m_tdata_i[7:0] !== want.out_byte)
            report_mismatch("out_byte", m_tdata_i[7:0], want.out_byte);
          if (m_tuser_i !== want.byte_valid)
            report_mismatch("byte_valid", {7'd0, m_tuser_i}, {7'd0, want.byte_valid});
          if (m_tdata_i[8] !== want.run_last)
            report_mismatch("run_last", {7'd0, m_tdata_i[8]}, {7'd0, want.run_last});
          if (m_tlast_i !== want.string_end)
            report_mismatch("string_end", {7'd0, m_tlast_i}, {7'd0, want.string_end});
          if (m_tdata_i[15:9] !== 7'd0)
            report_mismatch("tdata pad", {1'b0, m_tdata_i[15:9]}, 8'h00);
        end
        results_o++;
      end
    end
    pending_o = decoded_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the escape sequence decoder: clock, reset, string stimulus and verdict
module tb;
  import esd_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RANDOM_ITEMS = 500;
  localparam int RUN_LIMIT    = 4000000;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic [7:0]  ready_tick = 8'd0;

  int fail_cnt;
  int pending;
  int byte_cnt;
  int result_cnt;
  int double_cnt;
  int items_sent   = 0;
  int burst_left   = 0;
  int strings_sent = 0;

  logic [7:0] str_q[$];
  logic [7:0] simple_esc[6] = '{CH_N, CH_T, CH_E, CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE};

  escape_sequence_decoder DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  esd_checker decode_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tlast_i  (m_tlast),
    .m_tuser_i  (m_tuser),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .bytes_o    (byte_cnt),
    .results_o  (result_cnt),
    .doubles_o  (double_cnt)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // receiver: always ready, coin flip, one in four, mostly ready
  always @(posedge clk) begin
    ready_tick <= ready_tick + 8'd1;
    case (ready_tick[7:6])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (ready_tick[1:0] == 2'd0);
      default: m_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  function automatic logic [7:0] hex_char();
    case ($urandom_range(0, 3))
      0: return CH_ZERO + 8'($urandom_range(0, 9));
      1: return CH_LA + 8'($urandom_range(0, 5));
      2: return CH_UA + 8'($urandom_range(0, 5));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_string();
    foreach (str_q[i]) send_item(str_q[i], i == str_q.size() - 1);
    strings_sent++;
  endtask

  task automatic hold_off();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic add_char(input logic [7:0] c);
    str_q = {str_q, c};
  endtask

  task automatic build_string();
    int ntok;
    int kind;
    str_q.delete();
    add_char(($urandom_range(0, 3) == 0) ? 8'($urandom) : CH_DQUOTE);
    ntok = $urandom_range(0, 8);
    repeat (ntok) begin
      kind = $urandom_range(0, 19);
      if (kind <= 5) begin
        add_char(8'($urandom));
      end else if (kind <= 8) begin
        add_char(CH_BACKSLASH);
        add_char(simple_esc[$urandom_range(0, 5)]);
      end else if (kind <= 11) begin
        add_char(CH_BACKSLASH);
        add_char(CH_X);
        repeat (2) add_char(hex_char());
      end else if (kind <= 14) begin
        add_char(CH_BACKSLASH);
        add_char(CH_ZERO);
        repeat ($urandom_range(0, 4)) add_char(CH_ZERO + 8'($urandom_range(0, 7)));
      end else if (kind == 15) begin
        add_char(CH_BACKSLASH);
        add_char(8'($urandom));
      end else if (kind == 16) begin
        add_char(CH_BACKSLASH);
      end else begin
        add_char(8'($urandom_range(32, 126)));
      end
    end
    if ($urandom_range(0, 1) == 1) add_char(CH_DQUOTE);
    // cut the tail now and then so strings end inside escapes
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) if (str_q.size() > 1) str_q = str_q[0:$-1];
    end
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    str_q = '{CH_DQUOTE};
    send_string();
    str_q = '{CH_DQUOTE, 8'hFF, CH_BACKSLASH, CH_N, CH_BACKSLASH, CH_X, CH_LA, CH_UF,
              CH_BACKSLASH, CH_ZERO, CH_SEVEN, CH_SEVEN, CH_SEVEN, 8'h00,
              CH_BACKSLASH, CH_ZERO, CH_ZERO + 8'd1, CH_BACKSLASH};
    send_string();
    str_q = '{CH_DQUOTE, CH_BACKSLASH, CH_X, CH_UA};
    send_string();
    str_q = '{CH_DQUOTE, CH_BACKSLASH, CH_ZERO};
    send_string();
    hold_off();

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      build_string();
      send_string();
      if (strings_sent % 12 == 0) hold_off();
    end

    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("fed %0d bytes in %0d strings, %0d of them broke an octal run into two results",
             byte_cnt, strings_sent, double_cnt);
    $display("compared %0d decoded results, %0d mismatches", result_cnt, fail_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timed out with %0d results outstanding", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule
